>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the sorted array merge RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked assertion, disabled while reset is high.
`define SAM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SAM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SAM_ASSERT(lbl, clk, rst, prop, msg)
`define SAM_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> rtl/core/sam_pkg.sv
// ---------------------------------------------------------------------------
// sam_pkg
// Types, codes and defaults of the sorted array merge block.
// ---------------------------------------------------------------------------
`default_nettype none

package sam_pkg;

  localparam int DEPTH_DEFAULT = 32;
  localparam int VALUE_W       = 32;

  typedef logic [1:0]                action_t;
  typedef logic signed [VALUE_W-1:0] value_t;

  localparam action_t ACT_LOAD_BASE   = 2'd0;
  localparam action_t ACT_LOAD_INSERT = 2'd1;
  localparam action_t ACT_MERGE       = 2'd2;

  typedef enum logic [1:0] {
    STAT_ELEM    = 2'd0,
    STAT_ACCEPT  = 2'd1,
    STAT_DROPPED = 2'd2,
    STAT_EMPTY   = 2'd3
  } status_t;

endpackage

`default_nettype wire

>>> rtl/core/sam_if.sv
// ---------------------------------------------------------------------------
// sam_if
// Valid/ready channels for load/merge commands and for merge results.
// ---------------------------------------------------------------------------
`default_nettype none

interface sam_in_if;
  logic              valid;
  logic              ready;
  sam_pkg::action_t  action;
  sam_pkg::value_t   value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface sam_out_if;
  logic              valid;
  logic              ready;
  sam_pkg::value_t   value_res;
  sam_pkg::status_t  status;
  logic              last;

  modport source (output valid, output value_res, output status, output last,
                  input ready);
  modport sink   (input valid, input value_res, input status, input last,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/sam_list_mem.sv
// ---------------------------------------------------------------------------
// sam_list_mem
// One list store: single write port, single registered read port, with
// write data forwarded when both ports hit the same entry.
// ---------------------------------------------------------------------------
`default_nettype none

module sam_list_mem #(
  parameter int DEPTH = sam_pkg::DEPTH_DEFAULT,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire sam_pkg::value_t wdata,
  input  wire logic [AW-1:0]   raddr,
  output sam_pkg::value_t      rdata
);

  sam_pkg::value_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Write-first: a read of the entry being written returns the new value.
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sorted_array_merge.sv
// ---------------------------------------------------------------------------
// sorted_array_merge
// Two-list store with an ascending merge that streams the combined list.
// ---------------------------------------------------------------------------
// A load command returns one acknowledge (accepted, or dropped when its list
// already holds DEPTH entries). An accepted merge command then streams one
// element per cycle while the output is not stalled, one for each entry of
// both lists; the two list heads are read ahead from the single read port of
// each list memory so the compare and the next read overlap. Equal values
// put the insert-list element first. A merge with both lists empty returns a
// single empty report. New commands are held off while a merge streams, and
// a command is taken only when the output register is empty or its result
// leaves in the same cycle.
// The memories need no clearing after reset: only entries below the fill
// counts are ever read.
`default_nettype none

module sorted_array_merge #(
  parameter int DEPTH = sam_pkg::DEPTH_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  sam_in_if.sink     in_ch,
  sam_out_if.source  out_ch
);

  `include "assert_macros.svh"

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CW-1:0] FULL = CW'(DEPTH);
  localparam logic [CW-1:0] ONE  = CW'(1);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_MERGE = 2'b10
  } state_t;

  state_t            state, state_next;
  logic [CW-1:0]     base_count, base_count_next;
  logic [CW-1:0]     insert_count, insert_count_next;
  logic [CW-1:0]     bi, bi_next;
  logic [CW-1:0]     ii, ii_next;

  logic              ov, ov_next;
  sam_pkg::value_t   o_val, o_val_next;
  sam_pkg::status_t  o_stat, o_stat_next;
  logic              o_last, o_last_next;

  sam_pkg::value_t   b_head, i_head;
  logic              b_we, i_we;
  logic              out_free, in_fire, emit;
  logic              b_more, i_more, take_ins, pick_last;

  assign out_free    = !ov || out_ch.ready;
  assign in_ch.ready = (state == ST_IDLE) && out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign emit        = (state == ST_MERGE) && out_free;

  assign b_more   = bi < base_count;
  assign i_more   = ii < insert_count;
  assign take_ins = i_more && (!b_more || (i_head <= b_head));
  assign pick_last = take_ins ? ((ii + ONE == insert_count) && !b_more)
                              : ((bi + ONE == base_count) && !i_more);

  assign b_we = in_fire && (in_ch.action == sam_pkg::ACT_LOAD_BASE) && (base_count != FULL);
  assign i_we = in_fire && (in_ch.action == sam_pkg::ACT_LOAD_INSERT)
                && (insert_count != FULL);

  // Read addresses follow the next pointers so the heads are ready each cycle.
  sam_list_mem #(.DEPTH(DEPTH)) u_base_mem (
    .clk   (clk),
    .we    (b_we),
    .waddr (base_count[AW-1:0]),
    .wdata (in_ch.value),
    .raddr (bi_next[AW-1:0]),
    .rdata (b_head)
  );

  sam_list_mem #(.DEPTH(DEPTH)) u_insert_mem (
    .clk   (clk),
    .we    (i_we),
    .waddr (insert_count[AW-1:0]),
    .wdata (in_ch.value),
    .raddr (ii_next[AW-1:0]),
    .rdata (i_head)
  );

  always_comb begin
    state_next        = state;
    base_count_next   = base_count;
    insert_count_next = insert_count;
    bi_next           = bi;
    ii_next           = ii;
    ov_next           = ov && !out_ch.ready;
    o_val_next        = o_val;
    o_stat_next       = o_stat;
    o_last_next       = o_last;

    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_ch.action)
            sam_pkg::ACT_LOAD_BASE: begin
              ov_next     = 1'b1;
              o_val_next  = '0;
              o_last_next = 1'b1;
              if (base_count == FULL) begin
                o_stat_next = sam_pkg::STAT_DROPPED;
              end else begin
                o_stat_next     = sam_pkg::STAT_ACCEPT;
                base_count_next = base_count + ONE;
              end
            end
            sam_pkg::ACT_LOAD_INSERT: begin
              ov_next     = 1'b1;
              o_val_next  = '0;
              o_last_next = 1'b1;
              if (insert_count == FULL) begin
                o_stat_next = sam_pkg::STAT_DROPPED;
              end else begin
                o_stat_next       = sam_pkg::STAT_ACCEPT;
                insert_count_next = insert_count + ONE;
              end
            end
            sam_pkg::ACT_MERGE: begin
              if ((base_count == '0) && (insert_count == '0)) begin
                ov_next     = 1'b1;
                o_val_next  = '0;
                o_stat_next = sam_pkg::STAT_EMPTY;
                o_last_next = 1'b1;
              end else begin
                state_next = ST_MERGE;
              end
            end
            default: begin
              // unused code: drop the transaction
            end
          endcase
        end
      end
      ST_MERGE: begin
        if (emit) begin
          ov_next     = 1'b1;
          o_stat_next = sam_pkg::STAT_ELEM;
          o_last_next = pick_last;
          if (take_ins) begin
            o_val_next = i_head;
            ii_next    = ii + ONE;
          end else begin
            o_val_next = b_head;
            bi_next    = bi + ONE;
          end
          if (pick_last) begin
            state_next        = ST_IDLE;
            bi_next           = '0;
            ii_next           = '0;
            base_count_next   = '0;
            insert_count_next = '0;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      base_count   <= '0;
      insert_count <= '0;
      bi           <= '0;
      ii           <= '0;
      ov           <= 1'b0;
    end else begin
      state        <= state_next;
      base_count   <= base_count_next;
      insert_count <= insert_count_next;
      bi           <= bi_next;
      ii           <= ii_next;
      ov           <= ov_next;
    end
  end

  always_ff @(posedge clk) begin
    o_val  <= o_val_next;
    o_stat <= o_stat_next;
    o_last <= o_last_next;
  end

  assign out_ch.valid     = ov;
  assign out_ch.value_res = o_val;
  assign out_ch.status    = o_stat;
  assign out_ch.last      = o_last;

  `SAM_ASSERT(a_no_cmd_in_merge, clk, rst, (state == ST_MERGE) |-> !in_ch.ready, "command taken during merge")
  `SAM_ASSERT(a_ptr_in_range, clk, rst, (bi <= base_count) && (ii <= insert_count), "merge pointer beyond fill count")
  `SAM_ASSERT(a_count_in_range, clk, rst, (base_count <= FULL) && (insert_count <= FULL), "fill count beyond depth")
  `SAM_ASSERT(a_merge_clears, clk, rst, (emit && pick_last) |=> ((state == ST_IDLE) && (base_count == '0) && (insert_count == '0) && o_last), "lists not emptied after final element")
  `SAM_ASSERT(a_merge_has_work, clk, rst, (state == ST_MERGE) |-> (b_more || i_more), "merge running with no element left")

endmodule

`default_nettype wire

>>> test/merge_checker.sv
// ----------------------------------------------------------------------------
// merge_checker
// Watches the command and result channels of sorted_array_merge, keeps its
// own copy of both lists, predicts every result of each accepted command and
// compares the results that come out, in order, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module merge_checker
  import sam_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    in_ready,
  input  wire action_t in_action,
  input  wire value_t  in_value,
  input  wire logic    out_valid,
  input  wire logic    out_ready,
  input  wire value_t  out_value_res,
  input  wire status_t out_status,
  input  wire logic    out_last,
  output int           fail_count,
  output int           pending,
  output int           results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    value_t  value_res;
    status_t status;
    logic    last;
  } merge_result_t;

  value_t        base_vals [DEPTH];
  value_t        ins_vals  [DEPTH];
  int            base_n;
  int            ins_n;
  merge_result_t result_q [$];

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
    base_n       = 0;
    ins_n        = 0;
  end

  task automatic report_mismatch(string msg);
    fail_count++;
    if (fail_count <= 40) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  task automatic add_result(value_t v, status_t s, logic l);
    merge_result_t r;
    r.value_res = v;
    r.status    = s;
    r.last      = l;
    result_q.push_back(r);
  endtask

  // Predict the results of one accepted command and update the list copies.
  task automatic apply_command(action_t act, value_t val);
    int     i;
    int     j;
    int     total;
    value_t pick;
    case (act)
      ACT_LOAD_BASE: begin
        if (base_n >= DEPTH) begin
          add_result('0, STAT_DROPPED, 1'b1);
        end else begin
          base_vals[base_n] = val;
          base_n++;
          add_result('0, STAT_ACCEPT, 1'b1);
        end
      end
      ACT_LOAD_INSERT: begin
        if (ins_n >= DEPTH) begin
          add_result('0, STAT_DROPPED, 1'b1);
        end else begin
          ins_vals[ins_n] = val;
          ins_n++;
          add_result('0, STAT_ACCEPT, 1'b1);
        end
      end
      ACT_MERGE: begin
        total = base_n + ins_n;
        if (total == 0) begin
          add_result('0, STAT_EMPTY, 1'b1);
        end else begin
          i = 0;
          j = 0;
          for (int k = 0; k < total; k++) begin
            // take the insert head on a tie
            if (j < ins_n && (i >= base_n || ins_vals[j] <= base_vals[i])) begin
              pick = ins_vals[j];
              j++;
            end else begin
              pick = base_vals[i];
              i++;
            end
            add_result(pick, STAT_ELEM, k == total - 1);
          end
        end
        base_n = 0;
        ins_n  = 0;
      end
      default: ;  // unused code: no state change, no result
    endcase
  endtask

  always @(posedge clk) begin
    merge_result_t exp_r;
    if (rst) begin
      result_q.delete();
      base_n = 0;
      ins_n  = 0;
    end else begin
      if (in_valid && in_ready) begin
        apply_command(in_action, in_value);
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (result_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result value=%0d status=%s last=%0b",
                                    out_value_res, out_status.name(), out_last));
        end else begin
          exp_r = result_q.pop_front();
          if (out_value_res !== exp_r.value_res || out_status !== exp_r.status ||
              out_last !== exp_r.last) begin
            report_mismatch($sformatf(
              "got value=%0d status=%s last=%0b, want value=%0d status=%s last=%0b",
              out_value_res, out_status.name(), out_last,
              exp_r.value_res, exp_r.status.name(), exp_r.last));
          end
        end
      end
    end
    pending = result_q.size();
  end

endmodule

`default_nettype wire

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for sorted_array_merge: directed loads and merges at
// the value extremes, then random batches of loads, most followed by a merge, with
// random gaps on both channels and a checker that predicts every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sam_pkg::*;

  localparam int      DEPTH       = DEPTH_DEFAULT;
  localparam int      ITEM_TARGET = 210;
  localparam int      STALL_LIMIT = 2000;
  localparam int      TAIL_CYCLES = 20;
  localparam action_t ACT_UNUSED  = 2'd3;
  localparam value_t  VAL_MIN     = 32'sh8000_0000;
  localparam value_t  VAL_MAX     = 32'sh7FFF_FFFF;

  logic clk;
  logic rst;
  bit   quiet;
  int   cmds_sent;
  int   merges_sent;
  int   fails;
  int   pending;
  int   results_seen;
  int   stall_cycles;

  sam_in_if  in_ch ();
  sam_out_if out_ch ();

  sorted_array_merge dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  merge_checker #(.DEPTH(DEPTH)) chk (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_action     (in_ch.action),
    .in_value      (in_ch.value),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_value_res (out_ch.value_res),
    .out_status    (out_ch.status),
    .out_last      (out_ch.last),
    .fail_count    (fails),
    .pending       (pending),
    .results_seen  (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: stall now and then unless in a quiet stretch.
  always @(negedge clk) begin
    out_ch.ready <= !rst && (quiet || $urandom_range(99) >= 11);
  end

  initial begin : watchdog
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic value_t rand_value();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) begin
      return value_t'($urandom);
    end else if (pick < 75) begin
      // narrow range so ties are common
      return value_t'($urandom_range(15)) - 8;
    end else begin
      case ($urandom_range(5))
        0:       return VAL_MIN;
        1:       return VAL_MAX;
        2:       return 0;
        3:       return -1;
        4:       return VAL_MIN + 1;
        default: return VAL_MAX - 1;
      endcase
    end
  endfunction

  // Entered and left at a falling edge; valid stays high after a transaction.
  task automatic send_cmd(action_t act, value_t val);
    while (!quiet && $urandom_range(99) < 11) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.value  <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    if (act != ACT_UNUSED) cmds_sent++;
    if (act == ACT_MERGE) merges_sent++;
  endtask

  // Hold the sender until every predicted result has come out.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic run_batch(int nb, int ni, bit ordered, bit do_merge);
    value_t bq [$];
    value_t iq [$];
    int     bi;
    int     ii;
    for (int k = 0; k < nb; k++) bq.push_back(rand_value());
    for (int k = 0; k < ni; k++) iq.push_back(rand_value());
    if (ordered) begin
      bq.sort();
      iq.sort();
    end
    bi = 0;
    ii = 0;
    while (bi < nb || ii < ni) begin
      if ($urandom_range(99) < 4) begin
        send_cmd(ACT_UNUSED, rand_value());
      end else if (nb <= DEPTH && $urandom_range(99) < 3) begin
        // stray merge in the middle of a batch; keep overfill runs free of it
        send_cmd(ACT_MERGE, rand_value());
      end else if (ii >= ni || (bi < nb && $urandom_range(1) == 0)) begin
        send_cmd(ACT_LOAD_BASE, bq[bi]);
        bi++;
      end else begin
        send_cmd(ACT_LOAD_INSERT, iq[ii]);
        ii++;
      end
    end
    if (do_merge) send_cmd(ACT_MERGE, rand_value());
  endtask

  initial begin
    int nb;
    int ni;
    int batch;
    rst          = 1'b1;
    quiet        = 1'b0;
    cmds_sent    = 0;
    merges_sent  = 0;
    in_ch.valid  = 1'b0;
    in_ch.action = ACT_LOAD_BASE;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty merge, unused code, extremes with ties, one-sided and
    // unsorted lists.
    send_cmd(ACT_MERGE, VAL_MAX);
    send_cmd(ACT_UNUSED, -1);
    send_cmd(ACT_LOAD_BASE, VAL_MIN);
    send_cmd(ACT_LOAD_INSERT, VAL_MIN);
    send_cmd(ACT_LOAD_BASE, -1);
    send_cmd(ACT_LOAD_INSERT, 0);
    send_cmd(ACT_LOAD_BASE, VAL_MAX);
    send_cmd(ACT_LOAD_INSERT, VAL_MAX);
    send_cmd(ACT_MERGE, 0);
    send_cmd(ACT_LOAD_INSERT, 7);
    send_cmd(ACT_LOAD_INSERT, 7);
    send_cmd(ACT_MERGE, -1);
    send_cmd(ACT_LOAD_BASE, 3);
    send_cmd(ACT_MERGE, 0);
    send_cmd(ACT_LOAD_BASE, 10);
    send_cmd(ACT_LOAD_BASE, -5);
    send_cmd(ACT_LOAD_INSERT, 3);
    send_cmd(ACT_LOAD_INSERT, -20);
    send_cmd(ACT_MERGE, 0);
    send_cmd(ACT_UNUSED, 32'sh1234_5678);
    send_cmd(ACT_MERGE, 0);
    drain_results();

    // Fill both lists past capacity with no gaps on either side.
    quiet = 1'b1;
    run_batch(DEPTH + 1, DEPTH + 1, 1'b1, 1'b1);
    quiet = 1'b0;

    batch = 0;
    while (cmds_sent < ITEM_TARGET) begin
      nb = ($urandom_range(9) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 5);
      ni = ($urandom_range(9) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 5);
      quiet = (batch >= 6 && batch < 11);
      run_batch(nb, ni, $urandom_range(99) < 80, $urandom_range(99) < 90);
      if (batch == 12) drain_results();
      batch++;
    end
    quiet = 1'b0;
    send_cmd(ACT_MERGE, 0);

    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("ran %0d commands (%0d merges) in %0d random batches, %0d results checked",
             cmds_sent, merges_sent, batch, results_seen);
    $display("mismatches: %0d", fails);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
